@@ design/jsf_pkg.sv @@
// ----------------------------------------------------------------------------
// jsf_pkg: shared types and constants for the joystick to SBUS frame encoder
// Frame layout constants, register indexes and the lane advance controls.
// ----------------------------------------------------------------------------
package jsf_pkg;

  localparam int SampleW  = 12;
  localparam int ChanW    = 11;
  localparam int ByteIdxW = 5;
  localparam int ProdW    = 23;

  localparam logic [SampleW-1:0]  AdcFull   = 12'd4095;
  localparam logic [10:0]         ScaleSpan = 11'd1600;
  localparam logic [ChanW-1:0]    SbusLow   = 11'd192;
  localparam logic [7:0]          SbusHeader = 8'h0F;
  localparam logic [7:0]          ZeroByte  = 8'h00;
  localparam logic [ByteIdxW-1:0] LastIdx   = 5'd24;

  // Frame byte positions: the header and the bytes that carry channel bits
  localparam logic [ByteIdxW-1:0] IdxRollLo   = 5'd1;
  localparam logic [ByteIdxW-1:0] IdxRollHi   = 5'd2;
  localparam logic [ByteIdxW-1:0] IdxPitchHi  = 5'd3;
  localparam logic [ByteIdxW-1:0] IdxHeader   = 5'd0;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_ROLL_OFFSET  = 1'b0,
    REG_PITCH_OFFSET = 1'b1
  } cfg_reg_t;

  // Pipeline advance strobes handed to the lanes
  typedef struct packed {
    logic s1_en;
    logic s2_en;
  } lane_adv_t;

endpackage

@@ design/joystick_to_sbus_frame.sv @@
// ----------------------------------------------------------------------------
// joystick_to_sbus_frame: joystick sample pair to SBUS frame encoder
// Two scaling lanes (roll, pitch) feed a merge/serializer emitting 25 words.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload                                    Word marks
// in_      in   tdata[11:0] roll, tdata[23:12] pitch       -
// out_     out  tdata[7:0] frame_byte, [12:8] byte_index   tlast = last_byte
// cfg_     in   cfg_addr 0 roll_offset, 1 pitch_offset     write on cfg_we
//
// Each frame is 25 words; the serializer sends one word per cycle while the
// output is not stalled. A taken pair passes through the product, channel
// and header registers, in that order. A new pair is taken while a frame is
// being sent, so frames leave back to back. Output stalls hold the pipeline in place.
// Reset clears the valid flags and the offset registers.
// ----------------------------------------------------------------------------
module joystick_to_sbus_frame (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [11:0] roll_sample, [23:12] pitch_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] frame_byte, [12:8] byte_index, rest zero
  output logic        out_tlast,  // last_byte
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [10:0] cfg_wdata
);

  logic [jsf_pkg::ChanW-1:0]   roll_off_r, pitch_off_r;
  logic                        v1_r, v1_nxt, v2_r, v2_nxt;
  logic                        s1_ready, s2_ready;
  logic                        load_ready;
  jsf_pkg::lane_adv_t          adv;
  logic [jsf_pkg::SampleW-1:0] roll_s, pitch_rev;
  logic [jsf_pkg::ChanW-1:0]   roll_ch, pitch_ch;

  // Offset registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roll_off_r  <= '0;
      pitch_off_r <= '0;
    end else if (cfg_we) begin
      unique case (jsf_pkg::cfg_reg_t'(cfg_addr))
        jsf_pkg::REG_ROLL_OFFSET:  roll_off_r  <= cfg_wdata;
        jsf_pkg::REG_PITCH_OFFSET: pitch_off_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline handshake: a stage moves on when the next one is free
  assign s2_ready  = !v2_r || load_ready;
  assign s1_ready  = !v1_r || s2_ready;
  assign in_tready = s1_ready;
  assign adv.s1_en = in_tvalid && s1_ready;
  assign adv.s2_en = v1_r && s2_ready;

  always_comb begin
    v1_nxt = adv.s1_en ? 1'b1 : (adv.s2_en ? 1'b0 : v1_r);
    v2_nxt = adv.s2_en ? 1'b1 : ((v2_r && load_ready) ? 1'b0 : v2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  // Pitch runs reversed: 4095 - y is the bitwise complement of y
  assign roll_s    = in_tdata[11:0];
  assign pitch_rev = ~in_tdata[23:12];

  jsf_lane u_roll (
    .clk    (clk),
    .adv    (adv),
    .sample (roll_s),
    .offset (roll_off_r),
    .chan   (roll_ch)
  );

  jsf_lane u_pitch (
    .clk    (clk),
    .adv    (adv),
    .sample (pitch_rev),
    .offset (pitch_off_r),
    .chan   (pitch_ch)
  );

  jsf_ser u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (v2_r),
    .load_ready (load_ready),
    .roll_ch    (roll_ch),
    .pitch_ch   (pitch_ch),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v1_r)
    else $error("accepted pair did not enter first stage");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !s2_ready) |=> v1_r)
    else $error("first stage lost a pair while blocked");

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !load_ready) |=> v2_r)
    else $error("channel stage lost a pair while serializer busy");

endmodule

@@ design/jsf_lane.sv @@
// ----------------------------------------------------------------------------
// jsf_lane: one axis scaling lane
// Scales a 12-bit sample by 1600/4095, adds 192 and the offset, wraps to 11b.
// Two register stages: product, then quotient plus offset.
// ----------------------------------------------------------------------------
module jsf_lane (
  input  logic                       clk,
  input  jsf_pkg::lane_adv_t         adv,
  input  logic [jsf_pkg::SampleW-1:0] sample,
  input  logic [jsf_pkg::ChanW-1:0]   offset,
  output logic [jsf_pkg::ChanW-1:0]   chan
);

  logic [jsf_pkg::ProdW-1:0] prod_r;
  logic [jsf_pkg::ProdW-1:0] prod_nxt;
  logic [jsf_pkg::ChanW-1:0] chan_r;
  logic [jsf_pkg::ChanW-1:0] chan_nxt;
  logic [jsf_pkg::ChanW-1:0] q_est;
  logic [12:0]               rem;
  logic [jsf_pkg::ChanW-1:0] quot;

  // Multiply the sample by the output span
  assign prod_nxt = jsf_pkg::ProdW'(sample) * jsf_pkg::ProdW'(jsf_pkg::ScaleSpan);

  always_ff @(posedge clk) begin
    if (adv.s1_en) begin
      prod_r <= prod_nxt;
    end
  end

  // Divide by 4095: n/4096 undershoots by at most one, remainder stays below 2*4095
  always_comb begin
    q_est    = prod_r[jsf_pkg::ProdW-1:12];
    rem      = {1'b0, prod_r[11:0]} + 13'(q_est);
    quot     = (rem >= 13'(jsf_pkg::AdcFull)) ? q_est + 11'd1 : q_est;
    chan_nxt = quot + jsf_pkg::SbusLow + offset;
  end

  always_ff @(posedge clk) begin
    if (adv.s2_en) begin
      chan_r <= chan_nxt;
    end
  end

  assign chan = chan_r;

endmodule

@@ design/jsf_ser.sv @@
// ----------------------------------------------------------------------------
// jsf_ser: frame merge and byte serializer
// Merges the two lane channels into a 25-byte SBUS frame, one word per cycle while out_tready is high.
// ----------------------------------------------------------------------------
module jsf_ser (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load_valid,
  output logic                         load_ready,
  input  logic [jsf_pkg::ChanW-1:0]    roll_ch,
  input  logic [jsf_pkg::ChanW-1:0]    pitch_ch,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [15:0]                  out_tdata,  // [7:0] frame_byte, [12:8] byte_index
  output logic                         out_tlast   // last_byte
);

  logic                          busy_r, busy_nxt;
  logic [jsf_pkg::ByteIdxW-1:0]  idx_r, idx_nxt;
  logic [7:0]                    byte_r, byte_nxt;
  logic [jsf_pkg::ChanW-1:0]     roll_r, pitch_r;
  logic                          at_last;
  logic                          out_fire;
  logic                          load_fire;

  // Byte k of the frame for the stored channels
  function automatic logic [7:0] frame_byte(input logic [jsf_pkg::ByteIdxW-1:0] k,
                                            input logic [jsf_pkg::ChanW-1:0] r,
                                            input logic [jsf_pkg::ChanW-1:0] p);
    logic [7:0] b;
    b = jsf_pkg::ZeroByte;
    unique case (k)
      jsf_pkg::IdxHeader:  b = jsf_pkg::SbusHeader;
      jsf_pkg::IdxRollLo:  b = r[7:0];
      jsf_pkg::IdxRollHi:  b = {p[4:0], r[10:8]};
      jsf_pkg::IdxPitchHi: b = {2'b00, p[10:5]};
      default:             b = jsf_pkg::ZeroByte;
    endcase
    return b;
  endfunction

  assign at_last    = (idx_r == jsf_pkg::LastIdx);
  assign out_fire   = busy_r && out_tready;
  assign load_ready = !busy_r || (out_tready && at_last);
  assign load_fire  = load_valid && load_ready;

  // Advance through the frame, load the next one as the last word leaves
  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    byte_nxt = byte_r;
    if (load_fire) begin
      busy_nxt = 1'b1;
      idx_nxt  = jsf_pkg::IdxHeader;
      byte_nxt = jsf_pkg::SbusHeader;
    end else if (out_fire) begin
      if (at_last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt  = idx_r + 5'd1;
        byte_nxt = frame_byte(idx_r + 5'd1, roll_r, pitch_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= jsf_pkg::IdxHeader;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  // Hold payload of the frame in flight
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    if (load_fire) begin
      roll_r  <= roll_ch;
      pitch_r <= pitch_ch;
    end
  end

  assign out_tvalid = busy_r;
  assign out_tdata  = {3'b000, idx_r, byte_r};
  assign out_tlast  = at_last;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r <= jsf_pkg::LastIdx))
    else $error("byte index beyond frame end");

  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && at_last && !load_valid) |=> !busy_r)
    else $error("serializer stayed busy after last word");

  a_load_header: assert property (@(posedge clk) disable iff (!rst_n)
    load_fire |=> (busy_r && idx_r == jsf_pkg::IdxHeader && byte_r == jsf_pkg::SbusHeader))
    else $error("new frame does not start with header");

endmodule

@@ verif/tb_joystick_to_sbus_frame.sv @@
// ----------------------------------------------------------------------------
// tb_joystick_to_sbus_frame: self-checking bench for the SBUS frame encoder
// Drives joystick sample pairs and offset writes. A behavioral frame builder
// predicts the 25 words of every frame, and each output word is checked in
// order against it. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_joystick_to_sbus_frame;
  timeunit 1ns;
  timeprecision 1ps;

  // One frame word as it leaves the block
  typedef struct packed {
    logic [7:0] data;
    logic [4:0] idx;
    logic       last;
  } sbus_word_t;

  // Directed row: samples, offsets in force, optional hand-computed channels
  typedef struct packed {
    logic [11:0] roll;
    logic [11:0] pitch;
    logic [10:0] roll_off;
    logic [10:0] pitch_off;
    logic        typed;
    logic [10:0] exp_roll;
    logic [10:0] exp_pitch;
  } stick_row_t;

  localparam int NumRows       = 16;
  localparam int RandPhases    = 6;
  localparam int PairsPerPhase = 50;
  localparam int DrainBound    = 4000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;   // [11:0] roll_sample, [23:12] pitch_sample
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [7:0] frame_byte, [12:8] byte_index
  logic        out_tlast;         // last_byte
  logic        cfg_we     = 1'b0;
  logic [0:0]  cfg_addr   = '0;
  logic [10:0] cfg_wdata  = '0;

  sbus_word_t  pending_words[$];
  logic [10:0] roll_trim  = '0;
  logic [10:0] pitch_trim = '0;
  logic        steady     = 1'b0;
  int          mismatches = 0;

  // Extremes, wrap of the offset sum, and hand-computed channel values
  stick_row_t directed_rows [NumRows] = '{
    '{12'd0,     12'd4095,  11'd0,    11'd0,    1'b1, 11'd192,  11'd192},
    '{12'd4095,  12'd0,     11'd0,    11'd0,    1'b1, 11'd1792, 11'd1792},
    '{12'd0,     12'd0,     11'd0,    11'd0,    1'b1, 11'd192,  11'd1792},
    '{12'd4095,  12'd4095,  11'd0,    11'd0,    1'b1, 11'd1792, 11'd192},
    '{12'd1,     12'd4094,  11'd0,    11'd0,    1'b1, 11'd192,  11'd192},
    '{12'd4094,  12'd1,     11'd0,    11'd0,    1'b1, 11'd1791, 11'd1791},
    '{12'd2048,  12'd2047,  11'd0,    11'd0,    1'b0, 11'd0,    11'd0},
    '{12'hAAA,   12'h555,   11'd0,    11'd0,    1'b0, 11'd0,    11'd0},
    '{12'h555,   12'hAAA,   11'd0,    11'd0,    1'b0, 11'd0,    11'd0},
    '{12'd0,     12'd4095,  11'd2047, 11'd2047, 1'b1, 11'd191,  11'd191},
    '{12'd4095,  12'd0,     11'd2047, 11'd2047, 1'b1, 11'd1791, 11'd1791},
    '{12'd1234,  12'd3210,  11'd2047, 11'd2047, 1'b0, 11'd0,    11'd0},
    '{12'd4095,  12'd4095,  11'd256,  11'd0,    1'b1, 11'd0,    11'd192},
    '{12'd2000,  12'd3000,  11'd0,    11'd1000, 1'b0, 11'd0,    11'd0},
    '{12'd4094,  12'd4094,  11'd1,    11'd2046, 1'b1, 11'd1792, 11'd190},
    '{12'h800,   12'h7FF,   11'd1,    11'd2046, 1'b0, 11'd0,    11'd0}
  };

  joystick_to_sbus_frame dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Map a 12-bit sample onto the 192..1792 channel range, truncating
  function automatic logic [10:0] scale_axis(logic [11:0] sample);
    int unsigned span;
    span = (int'(sample) * 1600) / 4095 + 192;
    return span[10:0];
  endfunction

  // Queue the 25 words of the frame that carries these two channels
  function automatic void queue_frame(logic [10:0] roll_ch, logic [10:0] pitch_ch);
    logic [175:0] payload;
    sbus_word_t   w;
    payload        = '0;
    payload[10:0]  = roll_ch;
    payload[21:11] = pitch_ch;
    for (int k = 0; k < 25; k++) begin
      if (k == 0) begin
        w.data = jsf_pkg::SbusHeader;
      end else if (k <= 22) begin
        w.data = payload[(k-1)*8 +: 8];
      end else begin
        w.data = jsf_pkg::ZeroByte;
      end
      w.idx  = 5'(k);
      w.last = (5'(k) == jsf_pkg::LastIdx);
      pending_words.push_back(w);
    end
  endfunction

  // Present one pair after a random gap; predict its frame once taken
  task automatic send_pair(logic [11:0] roll, logic [11:0] pitch, logic typed,
                           logic [10:0] exp_roll, logic [10:0] exp_pitch);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {pitch, roll};
    do @(posedge clk); while (!in_tready);
    if (typed) begin
      queue_frame(exp_roll, exp_pitch);
    end else begin
      queue_frame(scale_axis(roll) + roll_trim,
                  scale_axis(jsf_pkg::AdcFull - pitch) + pitch_trim);
    end
  endtask

  // Drop valid and wait for every predicted word, with a bound
  task automatic settle();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0 && waited < DrainBound) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  // Write both offsets while the block is idle
  task automatic load_offsets(logic [10:0] r_off, logic [10:0] p_off);
    settle();
    cfg_we    <= 1'b1;
    cfg_addr  <= jsf_pkg::REG_ROLL_OFFSET;
    cfg_wdata <= r_off;
    @(posedge clk);
    cfg_addr  <= jsf_pkg::REG_PITCH_OFFSET;
    cfg_wdata <= p_off;
    @(posedge clk);
    cfg_we    <= 1'b0;
    roll_trim  = r_off;
    pitch_trim = p_off;
  endtask

  function automatic logic [11:0] pick_sample();
    unique case ($urandom_range(0, 7))
      0:       return 12'd0;
      1:       return 12'd4095;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [10:0] pick_offset();
    unique case ($urandom_range(0, 3))
      0:       return 11'd0;
      1:       return 11'd2047;
      default: return 11'($urandom_range(0, 2047));
    endcase
  endfunction

  // Stall the output side at random between words
  initial begin : word_sink
    int hold;
    while (!rst_n) @(posedge clk);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 4);
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Check every accepted word against the oldest prediction
  always @(posedge clk) begin
    sbus_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: tdata %0h tlast %0b", out_tdata, out_tlast);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        if (out_tdata[7:0] !== want.data) begin
          $error("frame_byte: expected %0h, got %0h", want.data, out_tdata[7:0]);
          mismatches++;
        end
        if (out_tdata[12:8] !== want.idx) begin
          $error("byte_index: expected %0d, got %0d", want.idx, out_tdata[12:8]);
          mismatches++;
        end
        if (out_tlast !== want.last) begin
          $error("last_byte: expected %0b, got %0b", want.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  // Stimulus: directed rows, then random phases with fresh offsets
  initial begin : stimulus
    stick_row_t row;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NumRows; i++) begin
      row = directed_rows[i];
      if (row.roll_off != roll_trim || row.pitch_off != pitch_trim) begin
        load_offsets(row.roll_off, row.pitch_off);
      end
      send_pair(row.roll, row.pitch, row.typed, row.exp_roll, row.exp_pitch);
    end

    for (int ph = 0; ph < RandPhases; ph++) begin
      unique case (ph)
        0:       load_offsets(11'd2047, 11'd0);
        1:       load_offsets(11'd0, 11'd2047);
        default: load_offsets(pick_offset(), pick_offset());
      endcase
      steady = (ph == 2);
      repeat (PairsPerPhase) send_pair(pick_sample(), pick_sample(), 1'b0, '0, '0);
    end
    steady = 1'b0;

    settle();
    repeat (10) @(posedge clk);
    if (pending_words.size() != 0) begin
      $error("%0d predicted words never arrived", pending_words.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin : watchdog
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ joystick_to_sbus_frame.f @@
design/jsf_pkg.sv
design/jsf_lane.sv
design/jsf_ser.sv
design/joystick_to_sbus_frame.sv
verif/tb_joystick_to_sbus_frame.sv
